FILE: src/sali_pkg.sv
package sali_pkg;

    localparam int CAPACITY = 64;
    localparam int KEY_W    = 32;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int SLOT_W   = 6;
    localparam int LEN_W    = 7;

    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_FULL = 2'd1;
    localparam logic [1:0] STAT_DUP  = 2'd2;

    // What the traveling beat is doing as it passes a cell.
    typedef enum logic [1:0] {
        TOK_SEARCH,
        TOK_SHIFT,
        TOK_INS,
        TOK_DUP
    } tok_mode_t;

    typedef struct packed {
        logic             valid;
        tok_mode_t        mode;
        logic [KEY_W-1:0] key;
    } tok_t;

    typedef enum logic {
        CTL_IDLE,
        CTL_WALK
    } ctl_state_t;

endpackage

FILE: src/sorted_array_linked_list_insert_top.sv
// Channel   Dir  Handshake           Beat fields
// input     in   in_valid/in_stall   key[31:0] signed
// result    out  out_valid/out_stall status[1:0], slot[5:0], length[6:0]
//
// A key that is inserted or found duplicate walks the cell row, one cell per
// cycle, through all CAPACITY cells; the next key is not taken until its
// result has left the holding register. A full list answers without a walk:
// the result goes into the holding register at accept, and from there to the
// output register.
// Reset empties the list at once (every cell's used flag clears); no sweep.
// Input stalls during a walk and while the holding register is occupied; the
// holding register moves into the output register once that one is free.
module sorted_array_linked_list_insert_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic signed [31:0] key,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [5:0]  slot,
    output logic [6:0]  length
);

    localparam int EXT_W = sali_pkg::CNT_W + sali_pkg::LEN_W;

    // Cell row: keys held in ascending order, used cells packed at the front.
    // Slots are handed out in order since nothing is ever freed, so the slot
    // of a new key equals the count before it.
    sali_pkg::tok_t tok [0:sali_pkg::CAPACITY];

    sali_pkg::ctl_state_t state_reg;
    sali_pkg::ctl_state_t state_next;

    logic [sali_pkg::CNT_W-1:0] count_reg;
    logic [sali_pkg::CNT_W-1:0] count_next;
    logic [sali_pkg::CNT_W-1:0] count_inc;

    logic        pend_valid_reg;
    logic        pend_valid_next;
    logic [1:0]  pend_status_reg;
    logic [1:0]  pend_status_next;
    logic [5:0]  pend_slot_reg;
    logic [5:0]  pend_slot_next;
    logic [6:0]  pend_len_reg;
    logic [6:0]  pend_len_next;

    logic        out_valid_reg;
    logic        out_valid_next;
    logic [1:0]  out_status_reg;
    logic [5:0]  out_slot_reg;
    logic [6:0]  out_len_reg;

    logic             accept;
    logic             is_full;
    logic             launch;
    logic             done;
    logic             load_out;
    logic [EXT_W-1:0] cnt_ext;
    logic [EXT_W-1:0] inc_ext;

    assign is_full   = (count_reg == sali_pkg::CNT_W'(sali_pkg::CAPACITY));
    assign accept    = in_valid && !in_stall;
    assign launch    = accept && !is_full;
    assign done      = tok[sali_pkg::CAPACITY].valid;
    assign load_out  = pend_valid_reg && (!out_valid_reg || !out_stall);
    assign count_inc = count_reg + sali_pkg::CNT_W'(1);
    assign cnt_ext   = EXT_W'(count_reg);
    assign inc_ext   = EXT_W'(count_inc);

    // Head of the row: a fresh search beat.
    always_comb
    begin
        tok[0].valid = launch;
        tok[0].mode  = sali_pkg::TOK_SEARCH;
        tok[0].key   = key;
    end

    genvar gi;
    generate
        for (gi = 0; gi < sali_pkg::CAPACITY; gi++)
        begin : g_cell
            sali_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .tok_in  (tok[gi]),
                .tok_out (tok[gi+1])
            );
        end
    endgenerate

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sali_pkg::CTL_IDLE:
            begin
                if (launch)
                begin
                    state_next = sali_pkg::CTL_WALK;
                end
            end
            sali_pkg::CTL_WALK:
            begin
                if (done)
                begin
                    state_next = sali_pkg::CTL_IDLE;
                end
            end
        endcase
    end

    // Outputs of the controller
    always_comb
    begin
        unique case (state_reg)
            sali_pkg::CTL_IDLE: in_stall = pend_valid_reg;
            sali_pkg::CTL_WALK: in_stall = 1'b1;
        endcase
    end

    // Result capture: full answers at once, others when the beat leaves the row.
    always_comb
    begin
        pend_valid_next  = pend_valid_reg && !load_out;
        pend_status_next = pend_status_reg;
        pend_slot_next   = pend_slot_reg;
        pend_len_next    = pend_len_reg;
        count_next       = count_reg;
        if (accept && is_full)
        begin
            pend_valid_next  = 1'b1;
            pend_status_next = sali_pkg::STAT_FULL;
            pend_slot_next   = '0;
            pend_len_next    = cnt_ext[6:0];
        end
        else if (done)
        begin
            pend_valid_next = 1'b1;
            if (tok[sali_pkg::CAPACITY].mode == sali_pkg::TOK_DUP)
            begin
                pend_status_next = sali_pkg::STAT_DUP;
                pend_slot_next   = '0;
                pend_len_next    = cnt_ext[6:0];
            end
            else
            begin
                pend_status_next = sali_pkg::STAT_OK;
                pend_slot_next   = cnt_ext[5:0];
                pend_len_next    = inc_ext[6:0];
                count_next       = count_inc;
            end
        end
    end

    always_comb
    begin
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= sali_pkg::CTL_IDLE;
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_status_reg <= pend_status_next;
        pend_slot_reg   <= pend_slot_next;
        pend_len_reg    <= pend_len_next;
        if (load_out)
        begin
            out_status_reg <= pend_status_reg;
            out_slot_reg   <= pend_slot_reg;
            out_len_reg    <= pend_len_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = out_status_reg;
    assign slot      = out_slot_reg;
    assign length    = out_len_reg;

endmodule

FILE: src/sali_cell.sv
module sali_cell (
    input  logic          clk,
    input  logic          rst_n,
    input  sali_pkg::tok_t tok_in,
    output sali_pkg::tok_t tok_out
);

    logic                       used_reg;
    logic                       used_next;
    logic [sali_pkg::KEY_W-1:0] key_reg;
    logic [sali_pkg::KEY_W-1:0] key_next;
    sali_pkg::tok_t             tok_reg;
    sali_pkg::tok_t             tok_next;

    always_comb
    begin
        used_next = used_reg;
        key_next  = key_reg;
        tok_next  = tok_in;
        if (tok_in.valid)
        begin
            unique case (tok_in.mode)
                sali_pkg::TOK_SEARCH:
                begin
                    priority if (!used_reg)
                    begin
                        used_next     = 1'b1;
                        key_next      = tok_in.key;
                        tok_next.mode = sali_pkg::TOK_INS;
                    end
                    else if (key_reg == tok_in.key)
                    begin
                        tok_next.mode = sali_pkg::TOK_DUP;
                    end
                    else if ($signed(key_reg) > $signed(tok_in.key))
                    begin
                        // new key lands here, displaced key ripples onward
                        key_next      = tok_in.key;
                        tok_next.mode = sali_pkg::TOK_SHIFT;
                        tok_next.key  = key_reg;
                    end
                    else
                    begin
                        tok_next.mode = sali_pkg::TOK_SEARCH;
                    end
                end
                sali_pkg::TOK_SHIFT:
                begin
                    if (!used_reg)
                    begin
                        used_next     = 1'b1;
                        key_next      = tok_in.key;
                        tok_next.mode = sali_pkg::TOK_INS;
                    end
                    else
                    begin
                        key_next     = tok_in.key;
                        tok_next.key = key_reg;
                    end
                end
                sali_pkg::TOK_INS,
                sali_pkg::TOK_DUP:
                begin
                    tok_next = tok_in;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= 1'b0;
            tok_reg  <= '0;
        end
        else
        begin
            used_reg <= used_next;
            tok_reg  <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

    assign tok_out = tok_reg;

endmodule
